// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- rtl/udpdq_pkg.sv -----
// Package: types and constants of the UDP endpoint demultiplexer.
package udpdq_pkg;
	localparam int ENDPOINTS   = 16;
	localparam int QUEUE_DEPTH = 8;
	localparam int PAYLOAD_MAX = 1472;
	localparam int EW = (ENDPOINTS > 1) ? $clog2(ENDPOINTS) : 1;
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int HW = 5;

	typedef enum logic [2:0] {
		REQ_BIND    = 3'd0,
		REQ_UNBIND  = 3'd1,
		REQ_DELIVER = 3'd2,
		REQ_RECEIVE = 3'd3,
		REQ_DROPS   = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_RD, ST_DQ, ST_DONE
	} state_t;

	// queue bookkeeping of one endpoint
	typedef struct packed {
		logic [QW-1:0] head;
		logic [QW-1:0] tail;
		logic [CW-1:0] count;
		logic [31:0]   drops;
	} qctl_t;

	// one stored datagram descriptor
	typedef struct packed {
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [10:0] len;
		logic [15:0] pref;
	} desc_t;

	// write request toward the queue memories
	typedef struct packed {
		logic          ctl_we;
		logic [EW-1:0] ctl_idx;
		qctl_t         ctl;
		logic          desc_we;
		logic [EW+QW-1:0] desc_idx;
		desc_t         desc;
	} qwr_t;
endpackage

// ----- rtl/udpdq_qmem.sv -----
// Queue memories: per-endpoint control words and descriptor store.
module udpdq_qmem (
	input  logic                          clk,
	input  udpdq_pkg::qwr_t               wr,
	input  logic [udpdq_pkg::EW-1:0]      ctl_ra,
	input  logic [udpdq_pkg::EW+udpdq_pkg::QW-1:0] desc_ra,
	output udpdq_pkg::qctl_t              ctl_rd,
	output udpdq_pkg::desc_t              desc_rd
);
	import udpdq_pkg::*;
	qctl_t ctl_mem [ENDPOINTS];
	desc_t desc_mem [ENDPOINTS*QUEUE_DEPTH];

	// control word memory
	always_ff @(posedge clk) begin
		if (wr.ctl_we) begin
			ctl_mem[wr.ctl_idx] <= wr.ctl;
		end
		ctl_rd <= ctl_mem[ctl_ra];
	end

	// descriptor memory
	always_ff @(posedge clk) begin
		if (wr.desc_we) begin
			desc_mem[wr.desc_idx] <= wr.desc;
		end
		desc_rd <= desc_mem[desc_ra];
	end
endmodule

// ----- rtl/udp_endpoint_demux_queues.sv -----
// Top level: endpoint table, sequencer and queue memories.
//  channel | signals                               | beat taken when
//  request | start, busy, req_type .. capacity      | start && !busy
//  result  | done, success .. drop_count            | done high (one cycle)
// Bind and deliver scan the slots one slot a cycle (ST_SCAN); every item then
// passes ST_RD, ST_DQ and ST_DONE; the control memory's single read port and
// the scan set this. Reset clears the valid bits, the sequencer and done only;
// no clearing pass. The receiver cannot stall: done lasts one cycle.
module udp_endpoint_demux_queues (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] endpoint_address,
	input  logic [15:0] endpoint_port,
	input  logic [4:0]  endpoint_handle,
	input  logic [31:0] sender_address,
	input  logic [15:0] sender_port,
	input  logic [15:0] payload_ref,
	input  logic [10:0] datagram_length,
	input  logic [15:0] receive_capacity,
	output logic        done,
	output logic        success,
	output logic [4:0]  new_handle,
	output logic [31:0] got_sender_address,
	output logic [15:0] got_sender_port,
	output logic [10:0] got_length,
	output logic [15:0] got_payload_ref,
	output logic [31:0] drop_count
);
	import udpdq_pkg::*;

	state_t state_q, state_d;
	logic [ENDPOINTS-1:0] valid_q;
	logic [31:0] addr_q [ENDPOINTS];
	logic [15:0] port_q [ENDPOINTS];

	// latched request
	logic [2:0]  req_q;
	logic [31:0] ea_q, sa_q;
	logic [15:0] ep_q, sp_q, pref_q, cap_q;
	logic [4:0]  hdl_q;
	logic [10:0] len_q;

	// scan state
	logic [EW-1:0] idx_q;
	logic clash_q, free_f_q, exact_f_q, wild_f_q, sel_ok;
	logic [EW-1:0] free_q, exact_q, wild_q, sel;
	qctl_t ctl_q;

	qwr_t wr;
	logic [EW-1:0] ctl_ra;
	logic [EW+QW-1:0] desc_ra;
	qctl_t ctl_rd;
	desc_t desc_rd;

	udpdq_qmem u_qmem (
		.clk(clk), .wr(wr), .ctl_ra(ctl_ra), .desc_ra(desc_ra),
		.ctl_rd(ctl_rd), .desc_rd(desc_rd)
	);

	// handle check
	logic hdl_ok;
	logic [EW-1:0] hslot;
	always_comb begin
		hslot = EW'(hdl_q - 5'd1);
		hdl_ok = (hdl_q != 5'd0) && ({27'd0, hdl_q} <= ENDPOINTS) && valid_q[hslot];
	end

	logic del_ok;
	assign del_ok = (ep_q != 16'd0) && (sp_q != 16'd0) && (len_q != 11'd0)
		&& ({21'd0, len_q} <= PAYLOAD_MAX);

	logic is_last;
	assign is_last = (idx_q == EW'(ENDPOINTS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = (req_type == REQ_BIND || req_type == REQ_DELIVER)
				? ST_SCAN : ST_RD;
			ST_SCAN: if (is_last) state_d = ST_RD;
			ST_RD:   state_d = ST_DQ;
			ST_DQ:   state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// read addresses: selected slot, then its head descriptor as the control word arrives
	always_comb begin
		ctl_ra = (req_q == REQ_DELIVER || req_q == REQ_BIND) ? sel : hslot;
		desc_ra = {sel, ctl_rd.head};
	end

	// latch the request on start, then slot scan, one slot a cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			req_q <= req_type; ea_q <= endpoint_address; ep_q <= endpoint_port;
			hdl_q <= endpoint_handle; sa_q <= sender_address; sp_q <= sender_port;
			pref_q <= payload_ref; len_q <= datagram_length; cap_q <= receive_capacity;
			idx_q <= '0; clash_q <= 1'b0; free_f_q <= 1'b0;
			exact_f_q <= 1'b0; wild_f_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= is_last ? idx_q : idx_q + EW'(1);
			if (valid_q[idx_q] && port_q[idx_q] == ep_q) begin
				if (ea_q == 32'd0 || addr_q[idx_q] == 32'd0 || addr_q[idx_q] == ea_q)
					clash_q <= 1'b1;
				if (addr_q[idx_q] == ea_q && !exact_f_q) begin
					exact_f_q <= 1'b1; exact_q <= idx_q;
				end
				if (addr_q[idx_q] == 32'd0) begin
					wild_f_q <= 1'b1; wild_q <= idx_q;
				end
			end
			if (!valid_q[idx_q] && !free_f_q) begin
				free_f_q <= 1'b1; free_q <= idx_q;
			end
		end
	end

	// pick the slot: scan result for bind and deliver, handle slot otherwise
	always_comb begin
		sel_ok = 1'b0;
		sel = '0;
		if (req_q == REQ_BIND) begin
			sel_ok = free_f_q && !clash_q && ep_q != 16'd0; sel = free_q;
		end else if (req_q == REQ_DELIVER) begin
			sel_ok = del_ok && (exact_f_q || wild_f_q);
			sel = exact_f_q ? exact_q : wild_q;
		end else begin
			sel_ok = hdl_ok; sel = hslot;
		end
	end

	// control word arrives in ST_DQ (read issued in ST_RD), descriptor in ST_DONE
	always_ff @(posedge clk) begin
		if (state_q == ST_DQ) ctl_q <= ctl_rd;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == ST_DONE && sel_ok) begin
			if (req_q == REQ_BIND) valid_q[sel] <= 1'b1;
			else if (req_q == REQ_UNBIND) valid_q[sel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && sel_ok && req_q == REQ_BIND) begin
			addr_q[sel] <= ea_q; port_q[sel] <= ep_q;
		end
	end

	// write back and result
	logic full, fits, nonempty;
	assign full = ({1'b0, ctl_q.count} >= (CW+1)'(QUEUE_DEPTH));
	assign nonempty = (ctl_q.count != '0);
	assign fits = ({5'd0, desc_rd.len} <= cap_q);

	function automatic logic [QW-1:0] nxt(input logic [QW-1:0] i);
		nxt = ({1'b0, i} + (QW+1)'(1) >= (QW+1)'(QUEUE_DEPTH)) ? '0 : i + QW'(1);
	endfunction

	always_comb begin
		wr = '0;
		wr.ctl_idx = sel;
		wr.ctl = ctl_q;
		wr.desc_idx = {sel, ctl_q.tail};
		wr.desc = '{src_addr: sa_q, src_port: sp_q, len: len_q, pref: pref_q};
		if (state_q == ST_DONE && sel_ok) begin
			unique case (req_q)
				REQ_BIND: begin
					wr.ctl_we = 1'b1; wr.ctl = '0;
				end
				REQ_DELIVER: begin
					wr.ctl_we = 1'b1;
					if (full) wr.ctl.drops = ctl_q.drops + 32'd1;
					else begin
						wr.desc_we = 1'b1;
						wr.ctl.tail = nxt(ctl_q.tail);
						wr.ctl.count = ctl_q.count + CW'(1);
					end
				end
				REQ_RECEIVE: begin
					if (nonempty && fits) begin
						wr.ctl_we = 1'b1;
						wr.ctl.head = nxt(ctl_q.head);
						wr.ctl.count = ctl_q.count - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == ST_DONE);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			success <= 1'b0; new_handle <= '0; got_sender_address <= '0;
			got_sender_port <= '0; got_length <= '0; got_payload_ref <= '0;
			drop_count <= '0;
			if (sel_ok) begin
				case (req_q)
					REQ_BIND: begin
						success <= 1'b1; new_handle <= HW'(sel) + 5'd1;
					end
					REQ_UNBIND: success <= 1'b1;
					REQ_DELIVER: success <= !full;
					REQ_RECEIVE: if (nonempty && fits) begin
						success <= 1'b1; got_sender_address <= desc_rd.src_addr;
						got_sender_port <= desc_rd.src_port; got_length <= desc_rd.len;
						got_payload_ref <= desc_rd.pref;
					end
					REQ_DROPS: begin
						success <= 1'b1; drop_count <= ctl_q.drops;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- rtl/udpdq_checker.sv -----
// Port checker for the demultiplexer, bound to the top level.
`include "assert_macros.svh"
module udpdq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        success,
	input logic [4:0]  new_handle,
	input logic [31:0] drop_count
);
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
	`ASSERT_NEXT(a_done_one, clk, arst_n, done, !done, "done longer than one cycle")
	`ASSERT_IMPL(a_handle_ok, clk, arst_n, done && new_handle != 5'd0, success,
		"handle without success")
	`ASSERT_IMPL(a_fail_zero, clk, arst_n, done && !success,
		new_handle == 5'd0 && drop_count == 32'd0, "failed result not zero")
endmodule

bind udp_endpoint_demux_queues udpdq_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.success(success), .new_handle(new_handle), .drop_count(drop_count)
);

// ----- tb/sv/testbench.sv -----
// Testbench for the UDP endpoint demultiplexer: directed table, a queue fill, then random traffic.
`timescale 1ns / 1ps

module testbench;
	import udpdq_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int N_RANDOM = 640;
	localparam int N_TABLE = 23;

	// one request beat
	typedef struct {
		logic [2:0]  op;
		logic [31:0] ep_addr;
		logic [15:0] ep_port;
		logic [4:0]  handle;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [15:0] pref;
		logic [10:0] len;
		logic [15:0] cap;
	} request_t;

	// one result beat
	typedef struct {
		logic        ok;
		logic [4:0]  hnd;
		logic [31:0] src_addr;
		logic [15:0] src_port;
		logic [10:0] len;
		logic [15:0] pref;
		logic [31:0] drops;
	} reply_t;

	// directed row: request, whether the reply is typed in, the reply
	typedef struct {
		request_t req;
		bit       fixed;
		reply_t   rep;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  req_type;
	logic [31:0] endpoint_address;
	logic [15:0] endpoint_port;
	logic [4:0]  endpoint_handle;
	logic [31:0] sender_address;
	logic [15:0] sender_port;
	logic [15:0] payload_ref;
	logic [10:0] datagram_length;
	logic [15:0] receive_capacity;
	logic        done;
	logic        success;
	logic [4:0]  new_handle;
	logic [31:0] got_sender_address;
	logic [15:0] got_sender_port;
	logic [10:0] got_length;
	logic [15:0] got_payload_ref;
	logic [31:0] drop_count;

	udp_endpoint_demux_queues i_dut (.*);

	// endpoint table and queues as predicted
	bit          ep_valid [ENDPOINTS];
	logic [31:0] ep_addr_tab [ENDPOINTS];
	logic [15:0] ep_port_tab [ENDPOINTS];
	logic [31:0] ep_drops [ENDPOINTS];
	reply_t      ep_queue [ENDPOINTS][$];

	reply_t pending_replies[$];
	int     failures = 0;
	int     idle_cycles = 0;
	int     send_idle_pct = 27;
	logic [15:0] bound_ports[$];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic reply_t demux_predict(request_t r);
		reply_t o;
		int     s, exact, wild;
		bit     clash;
		o = '{default: '0};
		s = -1;
		if (r.handle != 0 && r.handle <= ENDPOINTS && ep_valid[r.handle - 1])
			s = r.handle - 1;
		case (r.op)
			REQ_BIND: begin
				clash = 0;
				if (r.ep_port != 0) begin
					foreach (ep_valid[i])
						if (ep_valid[i] && ep_port_tab[i] == r.ep_port &&
								(r.ep_addr == 0 || ep_addr_tab[i] == 0 ||
								ep_addr_tab[i] == r.ep_addr))
							clash = 1;
					if (!clash) begin
						for (int i = 0; i < ENDPOINTS; i++) begin
							if (!ep_valid[i]) begin
								ep_valid[i] = 1;
								ep_addr_tab[i] = r.ep_addr;
								ep_port_tab[i] = r.ep_port;
								ep_drops[i] = 0;
								ep_queue[i].delete();
								o.ok = 1;
								o.hnd = 5'(i + 1);
								break;
							end
						end
					end
				end
			end
			REQ_UNBIND: begin
				if (s >= 0) begin
					ep_valid[s] = 0;
					o.ok = 1;
				end
			end
			REQ_DELIVER: begin
				if (r.ep_port != 0 && r.src_port != 0 && r.len != 0 && r.len <= PAYLOAD_MAX) begin
					exact = -1;
					wild = -1;
					for (int i = 0; i < ENDPOINTS; i++) begin
						if (!ep_valid[i] || ep_port_tab[i] != r.ep_port) continue;
						if (ep_addr_tab[i] == r.ep_addr) begin
							exact = i;
							break;
						end
						if (ep_addr_tab[i] == 0) wild = i;
					end
					s = (exact >= 0) ? exact : wild;
					if (s >= 0) begin
						if (ep_queue[s].size() >= QUEUE_DEPTH) begin
							ep_drops[s]++;
						end else begin
							ep_queue[s].push_back('{1'b1, 5'd0, r.src_addr, r.src_port,
								r.len, r.pref, 32'd0});
							o.ok = 1;
						end
					end
				end
			end
			REQ_RECEIVE: begin
				if (s >= 0 && ep_queue[s].size() != 0 && ep_queue[s][0].len <= r.cap)
					o = ep_queue[s].pop_front();
			end
			REQ_DROPS: begin
				if (s >= 0) begin
					o.ok = 1;
					o.drops = ep_drops[s];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic request_t mk(logic [2:0] op, logic [31:0] ea, logic [15:0] ep,
			logic [4:0] h, logic [31:0] sa, logic [15:0] sp, logic [15:0] pr,
			logic [10:0] ln, logic [15:0] cp);
		request_t r;
		r = '{op, ea, ep, h, sa, sp, pr, ln, cp};
		return r;
	endfunction

	// random request, mostly aimed at bound ports and in-range handles
	function automatic request_t random_request();
		request_t r;
		int       k;
		r.ep_addr = ($urandom_range(0, 3) == 0) ? 32'd0 :
			(($urandom_range(0, 1) != 0) ? {30'd0, 2'($urandom_range(1, 3))} : $urandom());
		r.ep_port = ($urandom_range(0, 9) == 0) ? 16'd0 :
			((bound_ports.size() != 0 && $urandom_range(0, 3) != 0) ?
			bound_ports[$urandom_range(0, bound_ports.size() - 1)] : 16'($urandom()));
		r.handle = ($urandom_range(0, 9) == 0) ? 5'($urandom()) : 5'($urandom_range(1, 16));
		r.src_addr = $urandom();
		r.src_port = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom());
		r.pref = 16'($urandom());
		k = $urandom_range(0, 19);
		r.len = (k == 0) ? 11'd0 : (k == 1) ? 11'($urandom_range(PAYLOAD_MAX + 1, 2047)) :
			11'($urandom_range(1, PAYLOAD_MAX));
		r.cap = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(1000, 2047));
		k = $urandom_range(0, 99);
		r.op = (k < 15) ? REQ_BIND : (k < 22) ? REQ_UNBIND : (k < 60) ? REQ_DELIVER :
			(k < 88) ? REQ_RECEIVE : (k < 96) ? REQ_DROPS : 3'($urandom_range(5, 7));
		if (r.op == REQ_BIND && r.ep_port != 0 && bound_ports.size() < 24)
			bound_ports.push_back(r.ep_port);
		return r;
	endfunction

	// drive one beat and wait for acceptance; start drops only on an idle gap
	task automatic send_request(request_t r);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		start <= 1'b1;
		req_type <= r.op;
		endpoint_address <= r.ep_addr;
		endpoint_port <= r.ep_port;
		endpoint_handle <= r.handle;
		sender_address <= r.src_addr;
		sender_port <= r.src_port;
		payload_ref <= r.pref;
		datagram_length <= r.len;
		receive_capacity <= r.cap;
		do @(posedge clk); while (busy);
	endtask

	// result monitor
	always @(posedge clk) begin
		reply_t e;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				$error("result with no request outstanding");
				failures++;
			end else begin
				e = pending_replies.pop_front();
				if (success !== e.ok) begin
					$error("success exp %0h got %0h", e.ok, success); failures++;
				end
				if (new_handle !== e.hnd) begin
					$error("new_handle exp %0h got %0h", e.hnd, new_handle); failures++;
				end
				if (got_sender_address !== e.src_addr) begin
					$error("got_sender_address exp %0h got %0h", e.src_addr,
						got_sender_address); failures++;
				end
				if (got_sender_port !== e.src_port) begin
					$error("got_sender_port exp %0h got %0h", e.src_port,
						got_sender_port); failures++;
				end
				if (got_length !== e.len) begin
					$error("got_length exp %0h got %0h", e.len, got_length); failures++;
				end
				if (got_payload_ref !== e.pref) begin
					$error("got_payload_ref exp %0h got %0h", e.pref, got_payload_ref);
					failures++;
				end
				if (drop_count !== e.drops) begin
					$error("drop_count exp %0h got %0h", e.drops, drop_count); failures++;
				end
			end
		end
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		row_t     rows[N_TABLE];
		reply_t   p;
		request_t r;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = '0;
		endpoint_address = '0;
		endpoint_port = '0;
		endpoint_handle = '0;
		sender_address = '0;
		sender_port = '0;
		payload_ref = '0;
		datagram_length = '0;
		receive_capacity = '0;
		foreach (ep_valid[i]) begin
			ep_valid[i] = 0;
			ep_drops[i] = 0;
		end
		// directed table; fixed replies only where obvious
		rows[0]  = '{mk(REQ_DROPS, 0, 0, 1, 0, 0, 0, 0, 0), 1, '{default: '0}};
		rows[1]  = '{mk(REQ_BIND, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0), 1, '{default: '0}};
		rows[2]  = '{mk(REQ_BIND, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1,
			'{1'b1, 5'd1, 0, 0, 0, 0, 0}};
		rows[3]  = '{mk(REQ_BIND, 0, 16'hFFFF, 0, 0, 0, 0, 0, 0), 1, '{default: '0}};
		rows[4]  = '{mk(REQ_BIND, 0, 16'd7, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 5'd2, 0, 0, 0, 0, 0}};
		rows[5]  = '{mk(REQ_BIND, 32'h0A00_0001, 16'd7, 0, 0, 0, 0, 0, 0), 1, '{default: '0}};
		rows[6]  = '{mk(REQ_DELIVER, 32'h1, 16'd7, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
			11'd1472, 0), 0, '{default: '0}};
		rows[7]  = '{mk(REQ_DELIVER, 32'h1, 16'd7, 0, 1, 1, 0, 11'd1473, 0), 1, '{default: '0}};
		rows[8]  = '{mk(REQ_DELIVER, 32'h1, 16'd7, 0, 1, 1, 0, 11'd0, 0), 1, '{default: '0}};
		rows[9]  = '{mk(REQ_DELIVER, 32'h1, 16'd7, 0, 1, 0, 0, 11'd5, 0), 1, '{default: '0}};
		rows[10] = '{mk(REQ_DELIVER, 32'h1, 16'd0, 0, 1, 1, 0, 11'd5, 0), 1, '{default: '0}};
		rows[11] = '{mk(REQ_DELIVER, 32'h1, 16'd9, 0, 1, 1, 0, 11'd5, 0), 1, '{default: '0}};
		rows[12] = '{mk(REQ_RECEIVE, 0, 0, 2, 0, 0, 0, 0, 16'd1471), 1, '{default: '0}};
		rows[13] = '{mk(REQ_RECEIVE, 0, 0, 2, 0, 0, 0, 0, 16'hFFFF), 0, '{default: '0}};
		rows[14] = '{mk(REQ_RECEIVE, 0, 0, 2, 0, 0, 0, 0, 16'hFFFF), 1, '{default: '0}};
		rows[15] = '{mk(REQ_RECEIVE, 0, 0, 5'd31, 0, 0, 0, 0, 16'hFFFF), 1, '{default: '0}};
		rows[16] = '{mk(REQ_DROPS, 0, 0, 5'd17, 0, 0, 0, 0, 0), 1, '{default: '0}};
		rows[17] = '{mk(REQ_DROPS, 0, 0, 2, 0, 0, 0, 0, 0), 1, '{1'b1, 0, 0, 0, 0, 0, 0}};
		rows[18] = '{mk(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 5'd31, 32'hFFFF_FFFF, 16'hFFFF,
			16'hFFFF, 11'h7FF, 16'hFFFF), 1, '{default: '0}};
		rows[19] = '{mk(3'd5, 0, 0, 1, 0, 0, 0, 0, 0), 1, '{default: '0}};
		rows[20] = '{mk(REQ_UNBIND, 0, 0, 1, 0, 0, 0, 0, 0), 1, '{1'b1, 0, 0, 0, 0, 0, 0}};
		rows[21] = '{mk(REQ_UNBIND, 0, 0, 1, 0, 0, 0, 0, 0), 1, '{default: '0}};
		rows[22] = '{mk(REQ_UNBIND, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{default: '0}};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			p = demux_predict(rows[i].req);
			pending_replies.push_back(rows[i].fixed ? rows[i].rep : p);
			send_request(rows[i].req);
		end
		// fill one queue past full so drops are counted
		bound_ports.push_back(16'd7);
		repeat (10) begin
			r = mk(REQ_DELIVER, 32'h5, 16'd7, 0, $urandom(), 16'($urandom_range(1, 65535)),
				16'($urandom()), 11'($urandom_range(1, PAYLOAD_MAX)), 0);
			pending_replies.push_back(demux_predict(r));
			send_request(r);
		end
		// three idling phases of random traffic
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 73 : 0;
			for (int n = 0; n < N_RANDOM / 3; n++) begin
				r = random_request();
				pending_replies.push_back(demux_predict(r));
				send_request(r);
			end
			// hold off until all replies are back
			start <= 1'b0;
			while (pending_replies.size() != 0) @(posedge clk);
		end
		repeat (ENDPOINTS + 8) @(posedge clk);
		if (failures == 0 && pending_replies.size() == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end
endmodule

// ----- udp_endpoint_demux_queues.f -----
+incdir+rtl
rtl/udpdq_pkg.sv
rtl/udpdq_qmem.sv
rtl/udp_endpoint_demux_queues.sv
rtl/udpdq_checker.sv
tb/sv/testbench.sv
